### hdl/brace_matcher_line_report_defines.svh
// Assertion macros shared by the brace matcher RTL.
`ifndef BRACE_MATCHER_LINE_REPORT_DEFINES_SVH
`define BRACE_MATCHER_LINE_REPORT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BML_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BML_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/bml_pkg.sv
// Package with types, constants and sizes of the brace matcher.
`default_nettype none

package bml_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int LINE_W      = 16;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  localparam logic       CMD_TEXT   = 1'b0;
  localparam logic       CMD_FINISH = 1'b1;

  localparam logic [7:0] CHAR_OPEN  = 8'h7B;
  localparam logic [7:0] CHAR_CLOSE = 8'h7D;

  localparam logic [1:0] KIND_OPEN    = 2'd0;
  localparam logic [1:0] KIND_CLOSE   = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  typedef struct packed {
    logic              cmd;
    logic [7:0]        ch;
    logic [LINE_W-1:0] line_no;
  } bml_in_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [LINE_W-1:0] line_no_out;
    logic              valid_res;
    logic              overflowed;
    logic              last;
  } bml_out_t;

  typedef struct packed {
    logic text_take;
    logic pop_open;
    logic pop_close;
    logic load_line;
    logic load_verdict;
  } bml_cmd_t;

  typedef struct packed {
    logic open_empty;
    logic close_empty;
    logic out_free;
  } bml_status_t;

endpackage

`default_nettype wire

### hdl/bml_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bml_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hdl/bml_ctrl.sv
// Controller state machine: text intake and the report drain sequence.
`default_nettype none

module bml_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_cmd,
  input  wire bml_pkg::bml_status_t status,
  output bml_pkg::bml_cmd_t        cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PICK,
    S_EMIT,
    S_VERDICT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next        = state;
    cmd               = '0;
    cmd.text_take     = accept && (in_cmd == bml_pkg::CMD_TEXT);
    case (state)
      S_IDLE: begin
        if (accept && (in_cmd == bml_pkg::CMD_FINISH)) begin
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        // Open lines are reported before close lines, each from the top down.
        if (!status.open_empty) begin
          cmd.pop_open = 1'b1;
          state_next   = S_EMIT;
        end else if (!status.close_empty) begin
          cmd.pop_close = 1'b1;
          state_next    = S_EMIT;
        end else begin
          state_next = S_VERDICT;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.load_line = 1'b1;
          state_next    = S_PICK;
        end
      end
      S_VERDICT: begin
        if (status.out_free) begin
          cmd.load_verdict = 1'b1;
          state_next       = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### hdl/bml_dp.sv
// Datapath: the two line stacks, their depths, the overflow flag and the result register.
`default_nettype none

module bml_dp (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire bml_pkg::bml_in_t     in_item,
  input  wire bml_pkg::bml_cmd_t    cmd,
  output bml_pkg::bml_status_t      status,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output bml_pkg::bml_out_t         out_item
);

  logic [bml_pkg::DEPTH_W-1:0] open_depth;
  logic [bml_pkg::DEPTH_W-1:0] open_depth_next;
  logic [bml_pkg::DEPTH_W-1:0] close_depth;
  logic [bml_pkg::DEPTH_W-1:0] close_depth_next;
  logic [bml_pkg::DEPTH_W-1:0] open_top;
  logic [bml_pkg::DEPTH_W-1:0] close_top;
  logic                        overflow_flag;
  logic                        overflow_next;
  logic                        reported;
  logic                        is_open;
  logic                        is_close;
  logic                        open_full;
  logic                        close_full;
  logic                        open_empty;
  logic                        close_empty;
  logic                        open_wr;
  logic                        close_wr;
  logic [bml_pkg::LINE_W-1:0]  open_rd_data;
  logic [bml_pkg::LINE_W-1:0]  close_rd_data;
  logic [1:0]                  kind_sel;

  assign is_open     = (in_item.ch == bml_pkg::CHAR_OPEN);
  assign is_close    = (in_item.ch == bml_pkg::CHAR_CLOSE);
  assign open_full   = (open_depth >= bml_pkg::DEPTH_W'(bml_pkg::STACK_DEPTH));
  assign close_full  = (close_depth >= bml_pkg::DEPTH_W'(bml_pkg::STACK_DEPTH));
  assign open_empty  = (open_depth == '0);
  assign close_empty = (close_depth == '0);
  assign open_top    = open_depth - bml_pkg::DEPTH_W'(1);
  assign close_top   = close_depth - bml_pkg::DEPTH_W'(1);

  // A close brace lands on the close stack only when no open brace is waiting.
  assign open_wr  = cmd.text_take && is_open && !open_full;
  assign close_wr = cmd.text_take && is_close && open_empty && !close_full;

  assign status.open_empty  = open_empty;
  assign status.close_empty = close_empty;
  assign status.out_free    = !out_valid || out_ready;

  bml_ram #(
    .WIDTH(bml_pkg::LINE_W),
    .DEPTH(bml_pkg::STACK_DEPTH)
  ) u_open_ram (
    .clk    (clk),
    .wr_en  (open_wr),
    .wr_addr(open_depth[bml_pkg::ADDR_W-1:0]),
    .wr_data(in_item.line_no),
    .rd_en  (cmd.pop_open),
    .rd_addr(open_top[bml_pkg::ADDR_W-1:0]),
    .rd_data(open_rd_data)
  );

  bml_ram #(
    .WIDTH(bml_pkg::LINE_W),
    .DEPTH(bml_pkg::STACK_DEPTH)
  ) u_close_ram (
    .clk    (clk),
    .wr_en  (close_wr),
    .wr_addr(close_depth[bml_pkg::ADDR_W-1:0]),
    .wr_data(in_item.line_no),
    .rd_en  (cmd.pop_close),
    .rd_addr(close_top[bml_pkg::ADDR_W-1:0]),
    .rd_data(close_rd_data)
  );

  always_comb begin
    open_depth_next  = open_depth;
    close_depth_next = close_depth;
    overflow_next    = overflow_flag;
    if (cmd.text_take) begin
      if (is_open) begin
        if (open_full) begin
          overflow_next = 1'b1;
        end else begin
          open_depth_next = open_depth + bml_pkg::DEPTH_W'(1);
        end
      end else if (is_close) begin
        if (!open_empty) begin
          open_depth_next = open_top;
        end else if (close_full) begin
          overflow_next = 1'b1;
        end else begin
          close_depth_next = close_depth + bml_pkg::DEPTH_W'(1);
        end
      end
    end
    if (cmd.pop_open) begin
      open_depth_next = open_top;
    end
    if (cmd.pop_close) begin
      close_depth_next = close_top;
    end
    if (cmd.load_verdict) begin
      open_depth_next  = '0;
      close_depth_next = '0;
      overflow_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_depth    <= '0;
      close_depth   <= '0;
      overflow_flag <= 1'b0;
      reported      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      open_depth    <= open_depth_next;
      close_depth   <= close_depth_next;
      overflow_flag <= overflow_next;
      // The stacks are drained by the time the verdict is loaded, so any pop
      // during this report marks the text as unbalanced.
      if (cmd.load_verdict) begin
        reported <= 1'b0;
      end else if (cmd.pop_open || cmd.pop_close) begin
        reported <= 1'b1;
      end
      if (cmd.load_line || cmd.load_verdict) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop_open) begin
      kind_sel <= bml_pkg::KIND_OPEN;
    end else if (cmd.pop_close) begin
      kind_sel <= bml_pkg::KIND_CLOSE;
    end
    if (cmd.load_line) begin
      out_item.kind        <= kind_sel;
      out_item.line_no_out <= (kind_sel == bml_pkg::KIND_OPEN) ? open_rd_data : close_rd_data;
      out_item.valid_res   <= 1'b0;
      out_item.overflowed  <= overflow_flag;
      out_item.last        <= 1'b0;
    end else if (cmd.load_verdict) begin
      out_item.kind        <= bml_pkg::KIND_VERDICT;
      out_item.line_no_out <= '0;
      out_item.valid_res   <= !reported && !overflow_flag;
      out_item.overflowed  <= overflow_flag;
      out_item.last        <= 1'b1;
    end
  end

endmodule

`default_nettype wire

### hdl/brace_matcher_line_report.sv
// Top level of the brace matcher: controller, datapath and checks.
//
// Input channel in_valid/in_ready/in_item carries one text character with its
// line number, or a finish command. Output channel out_valid/out_ready/out_item
// carries report results: unmatched open lines from the top of the stack down,
// then unmatched close lines likewise, then one verdict marked with last.
// While idle, a text character is taken in every cycle and produces nothing.
// A finish transfer starts a drain: S_PICK reads each reported line from the
// stack RAM, whose read data is registered, S_EMIT loads it into the result
// register, and once both stacks are empty S_VERDICT loads the verdict.
// in_ready is low from the finish transfer until the verdict is loaded;
// after that, text is accepted while the verdict still waits.
// Each stack holds 16 lines; a brace pushed onto a full stack is dropped and
// marks the text as overflowed, which makes the verdict invalid.
// Reset empties both stacks, clears the overflow flag and the output valid flag;
// stack contents are not cleared. If the receiver stalls, the result stays
// in the output register and the drain waits for it.
`default_nettype none

`include "brace_matcher_line_report_defines.svh"

module brace_matcher_line_report (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire bml_pkg::bml_in_t  in_item,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output bml_pkg::bml_out_t      out_item
);

  bml_pkg::bml_cmd_t    cmd;
  bml_pkg::bml_status_t status;

  bml_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_cmd  (in_item.cmd),
    .status  (status),
    .cmd     (cmd)
  );

  bml_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_item),
    .cmd      (cmd),
    .status   (status),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  `BML_ASSERT_NOW(a_pop_nonempty, clk, rst, cmd.pop_open || cmd.pop_close, (cmd.pop_open && !status.open_empty) || (cmd.pop_close && !status.close_empty), "pop from an empty stack")
  `BML_ASSERT_NOW(a_load_free, clk, rst, cmd.load_line || cmd.load_verdict, status.out_free, "result loaded over an untaken result")
  `BML_ASSERT_NEXT(a_finish_busy, clk, rst, in_valid && in_ready && (in_item.cmd == bml_pkg::CMD_FINISH), !in_ready, "input taken during a report drain")
  `BML_ASSERT_NEXT(a_verdict_clears, clk, rst, cmd.load_verdict, status.open_empty && status.close_empty && out_valid && out_item.last, "verdict did not close the report")

endmodule

`default_nettype wire
